/* rtl/core/iiel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iiel_pkg;

    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 7;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // Operation codes carried in the func field of a request beat.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET        = 3'd0,
        FUNC_SET        = 3'd1,
        FUNC_ADD_BACK   = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_PUSH_FRONT = 3'd4,
        FUNC_DROP_FRONT = 3'd5,
        FUNC_INSERT     = 3'd6,
        FUNC_ERASE      = 3'd7
    } func_t;

    // What every cell of the row does at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [INDEX_W-1:0]        index;
        logic signed [WORD_W-1:0]  value;
    } req_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        logic                      ok;
        logic [COUNT_W-1:0]        count;
    } rsp_beat_t;

endpackage

`default_nettype wire

/* rtl/core/iiel_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module iiel_cell #(
    parameter int PW  = 7,
    parameter int POS = 0
) (
    input  wire logic                       clk,
    input  wire iiel_pkg::cell_cmd_t        cmd,
    input  wire logic [PW-1:0]              pos,
    input  wire logic [iiel_pkg::WORD_W-1:0] left_word,
    input  wire logic [iiel_pkg::WORD_W-1:0] right_word,
    output logic      [iiel_pkg::WORD_W-1:0] word,
    output logic      [iiel_pkg::WORD_W-1:0] hit_word
);
    import iiel_pkg::*;

    localparam logic [PW-1:0] POS_V = PW'(POS);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Each cell decides from the broadcast position where its next word comes from.
    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            CELL_LOAD:
            begin
                if (POS_V == pos)
                begin
                    word_next = cmd.word;
                end
            end
            CELL_INSERT:
            begin
                if (POS_V > pos)
                begin
                    word_next = left_word;
                end
                else if (POS_V == pos)
                begin
                    word_next = cmd.word;
                end
            end
            CELL_ERASE:
            begin
                if (POS_V >= pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign hit_word = (POS_V == pos) ? word_reg : '0;

endmodule

`default_nettype wire

/* rtl/core/indexed_insert_erase_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to CAPACITY signed 32-bit words with get, set, push and pop at
// both ends, and insert or erase at any index. The words live in a row of CAPACITY cells;
// an insert or erase moves every cell at or above the position by one place in the same
// clock edge, so no operation depends on the list length. Each request beat yields exactly
// one response beat: as it is accepted the cells are updated and the read word is gathered
// into group registers of 32 cells each, and the groups are then folded into the response
// register. A new request is refused while the groups are folded and while a response is
// held by a stall, but it is taken while a response is handed over, so the block can take
// a new request before the last response has left. Refused operations (index out of range,
// pop on an empty list, push on a full list) report ok low and leave the list unchanged; a
// refused get returns -1, every other non-get returns a read value of zero, and count is the
// entry count after the operation, truncated to seven bits.
module indexed_insert_erase_list #(
    parameter int CAPACITY = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire iiel_pkg::req_beat_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output iiel_pkg::rsp_beat_t      rsp
);
    import iiel_pkg::*;

    // Width of the stored count, and a common width for comparing it with the index.
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int W      = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int GROUP  = 32;
    localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_hit  [CAPACITY];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              gather_reg;
    logic              rsp_valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic              is_get_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [WORD_W-1:0] group_reg  [NGROUP];
    logic [WORD_W-1:0] group_next [NGROUP];
    logic [WORD_W-1:0] read_all;
    rsp_beat_t         rsp_reg;
    rsp_beat_t         rsp_next;

    cell_cmd_t         cmd;
    logic [W-1:0]      pos;
    logic [W-1:0]      idx_w;
    logic [W-1:0]      cnt_w;
    logic [W-1:0]      cnt_after_w;
    logic              accept;

    assign accept    = req_valid && !req_stall;
    assign req_stall = gather_reg || (rsp_valid_reg && rsp_stall);
    assign idx_w     = W'(req.index);
    assign cnt_w     = W'(count_reg);

    // Decode the request into a command broadcast to every cell, the check for
    // whether the operation may be done, and the count that follows it.
    always_comb
    begin
        cmd.op     = CELL_HOLD;
        cmd.word   = req.value;
        pos        = idx_w;
        ok_next    = 1'b0;
        count_next = count_reg;
        case (req.func)
            FUNC_GET:
            begin
                ok_next = idx_w < cnt_w;
            end
            FUNC_SET:
            begin
                ok_next = idx_w < cnt_w;
                cmd.op  = CELL_LOAD;
            end
            FUNC_ADD_BACK:
            begin
                ok_next    = cnt_w < W'(CAPACITY);
                cmd.op     = CELL_INSERT;
                pos        = cnt_w;
                count_next = CW'(count_reg + 1'b1);
            end
            FUNC_POP_BACK:
            begin
                ok_next    = count_reg != '0;
                count_next = CW'(count_reg - 1'b1);
            end
            FUNC_PUSH_FRONT:
            begin
                ok_next    = cnt_w < W'(CAPACITY);
                cmd.op     = CELL_INSERT;
                pos        = '0;
                count_next = CW'(count_reg + 1'b1);
            end
            FUNC_DROP_FRONT:
            begin
                ok_next    = count_reg != '0;
                cmd.op     = CELL_ERASE;
                pos        = '0;
                count_next = CW'(count_reg - 1'b1);
            end
            FUNC_INSERT:
            begin
                ok_next    = (idx_w <= cnt_w) && (cnt_w < W'(CAPACITY));
                cmd.op     = CELL_INSERT;
                count_next = CW'(count_reg + 1'b1);
            end
            default:
            begin
                ok_next    = idx_w < cnt_w;
                cmd.op     = CELL_ERASE;
                count_next = CW'(count_reg - 1'b1);
            end
        endcase
        // A refused operation, or a cycle without a beat, leaves the list as it is.
        if (!(accept && ok_next))
        begin
            cmd.op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    assign cnt_after_w = W'(count_next);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_W-1:0] left_word;
            logic [WORD_W-1:0] right_word;
            if (gi == 0)
            begin : g_first
                assign left_word = '0;
            end
            else
            begin : g_inner_left
                assign left_word = cell_word[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_word = cell_word[gi];
            end
            else
            begin : g_inner_right
                assign right_word = cell_word[gi+1];
            end
            iiel_cell #(
                .PW  (W),
                .POS (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (pos),
                .left_word  (left_word),
                .right_word (right_word),
                .word       (cell_word[gi]),
                .hit_word   (cell_hit[gi])
            );
        end

        // Only the cell at the read position drives a nonzero hit word, so an OR per
        // group of cells picks it out; the groups are registered before the final fold.
        for (gi = 0; gi < NGROUP; gi++)
        begin : g_group
            always_comb
            begin
                group_next[gi] = '0;
                for (int k = 0; k < GROUP; k++)
                begin
                    if (gi * GROUP + k < CAPACITY)
                    begin
                        group_next[gi] = group_next[gi] | cell_hit[gi * GROUP + k];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (accept)
                begin
                    group_reg[gi] <= group_next[gi];
                end
            end
        end
    endgenerate

    always_comb
    begin
        read_all = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            read_all = read_all | group_reg[g];
        end
    end

    always_comb
    begin
        rsp_next.ok    = ok_reg;
        rsp_next.count = count_out_reg;
        if (!is_get_reg)
        begin
            rsp_next.read_value = '0;
        end
        else if (ok_reg)
        begin
            rsp_next.read_value = read_all;
        end
        else
        begin
            rsp_next.read_value = -32'sd1;
        end
    end

    // Payload of the beat in flight; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok_next;
            is_get_reg    <= req.func == FUNC_GET;
            count_out_reg <= cnt_after_w[COUNT_W-1:0];
        end
        if (gather_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            gather_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            gather_reg <= accept;
            if (gather_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* dv/tb_indexed_insert_erase_list.sv */
`timescale 1ns / 1ps

// The list under test answers every request beat with exactly one response beat, in order.
// The scoreboard keeps its own copy of the list. Each accepted request beat updates that
// copy and queues the response it should produce. Each accepted response beat is checked
// against the oldest queued one.
module tb_indexed_insert_erase_list;

    import iiel_pkg::*;

    localparam int CAPACITY = 64;
    localparam int RANDOM_BEATS = 1000;

    // Scoreboard: a plain array that stands in for the row of cells, plus the entry count.
    class list_scoreboard;
        logic signed [WORD_W-1:0] words [CAPACITY];
        int fill;
        rsp_beat_t expected_rsp [$];
        int unsigned errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // Shift everything at and above pos up by one and store the word there.
        function bit open_slot(int pos, logic signed [WORD_W-1:0] w);
            if (pos > fill || fill >= CAPACITY)
                return 1'b0;
            for (int j = fill; j > pos; j--)
                words[j] = words[j - 1];
            words[pos] = w;
            fill++;
            return 1'b1;
        endfunction

        // Shift everything above pos down by one. The top word is left stale.
        function bit close_slot(int pos);
            if (pos >= fill)
                return 1'b0;
            for (int j = pos; j + 1 < fill; j++)
                words[j] = words[j + 1];
            fill--;
            return 1'b1;
        endfunction

        function void note_request(req_beat_t b);
            rsp_beat_t want;
            int pos;
            want = '0;
            pos = int'(b.index);
            case (func_t'(b.func))
                FUNC_GET:
                begin
                    if (pos < fill)
                    begin
                        want.read_value = words[pos];
                        want.ok = 1'b1;
                    end
                    else
                        want.read_value = -1;
                end
                FUNC_SET:
                begin
                    if (pos < fill)
                    begin
                        words[pos] = b.value;
                        want.ok = 1'b1;
                    end
                end
                FUNC_ADD_BACK:   want.ok = open_slot(fill, b.value);
                FUNC_POP_BACK:
                begin
                    if (fill > 0)
                    begin
                        fill--;
                        want.ok = 1'b1;
                    end
                end
                FUNC_PUSH_FRONT: want.ok = open_slot(0, b.value);
                FUNC_DROP_FRONT: want.ok = close_slot(0);
                FUNC_INSERT:     want.ok = open_slot(pos, b.value);
                default:         want.ok = close_slot(pos);
            endcase
            want.count = COUNT_W'(fill);
            expected_rsp.insert(expected_rsp.size(), want);
        endfunction

        function void check_response(rsp_beat_t got);
            rsp_beat_t want;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response beat, expected none, got %p", $time, got);
                return;
            end
            want = expected_rsp[0];
            expected_rsp.delete(0);
            if (got.read_value !== want.read_value)
            begin
                errors++;
                $display("%0t: read_value expected %0d got %0d", $time,
                         want.read_value, got.read_value);
            end
            if (got.ok !== want.ok)
            begin
                errors++;
                $display("%0t: ok expected %0b got %0b", $time, want.ok, got.ok);
            end
            if (got.count !== want.count)
            begin
                errors++;
                $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    // While this is set, neither side idles, so the block runs at its full rate.
    bit steady;

    list_scoreboard sb = new();

    indexed_insert_erase_list #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // About a third of the cycles are idle on each side, outside the steady stretch.
    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 33);
    endfunction

    function automatic req_beat_t make_beat(func_t f, int idx, logic signed [WORD_W-1:0] v);
        req_beat_t b;
        b.func = f;
        b.index = INDEX_W'(idx);
        b.value = v;
        return b;
    endfunction

    // Present one request beat and hold it until the block takes it. The task is entered
    // and left at a rising edge, so valid is only lowered when an idle cycle is wanted and
    // otherwise stays high into the next beat without a second assignment in the same step.
    task automatic send_beat(req_beat_t b);
        while (idle_roll())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= b;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(b);
    endtask

    // Random traffic that walks the list between empty and full. The walk heads one way
    // until it hits a bound, lingers there for a few beats so that refused pushes and
    // pops happen, then turns around. Gets and sets are mixed in throughout, and a tenth
    // of the indexes are drawn from the whole 7-bit field to hit out-of-range refusals.
    task automatic run_random(int n);
        bit rising;
        int roll;
        int idx;
        func_t op;
        logic signed [WORD_W-1:0] v;
        rising = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            steady = (i >= 400 && i < 600);
            if (sb.fill >= CAPACITY && $urandom_range(0, 7) == 0)
                rising = 1'b0;
            else if (sb.fill == 0 && $urandom_range(0, 7) == 0)
                rising = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                case ($urandom_range(0, 2))
                    0:       op = rising ? FUNC_ADD_BACK : FUNC_POP_BACK;
                    1:       op = rising ? FUNC_PUSH_FRONT : FUNC_DROP_FRONT;
                    default: op = rising ? FUNC_INSERT : FUNC_ERASE;
                endcase
            end
            else if (roll < 80)
                op = ($urandom_range(0, 1) == 0) ? FUNC_GET : FUNC_SET;
            else
                op = func_t'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                idx = $urandom_range(0, 127);
            else
                idx = $urandom_range(0, sb.fill);
            case ($urandom_range(0, 7))
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = -1;
                3:       v = 0;
                default: v = $urandom;
            endcase
            send_beat(make_beat(op, idx, v));
        end
        steady = 1'b0;
    endtask

    // Response side: check every accepted beat, then pick the stall for the next cycle.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            rsp_stall <= idle_roll();
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats. The list starts empty, so every access and every pop is refused
        // and a refused get must read back -1.
        send_beat(make_beat(FUNC_GET, 0, 0));
        send_beat(make_beat(FUNC_POP_BACK, 0, 0));
        send_beat(make_beat(FUNC_DROP_FRONT, 0, 0));
        send_beat(make_beat(FUNC_ERASE, 0, 0));
        send_beat(make_beat(FUNC_SET, 0, 32'sh1111_1111));
        // Insert past the end is refused, insert at the end is allowed.
        send_beat(make_beat(FUNC_INSERT, 1, 32'sh2222_2222));
        send_beat(make_beat(FUNC_INSERT, 0, 32'sh7FFF_FFFF));
        send_beat(make_beat(FUNC_ADD_BACK, 0, 32'sh8000_0000));
        send_beat(make_beat(FUNC_PUSH_FRONT, 0, -1));
        send_beat(make_beat(FUNC_INSERT, 3, 0));
        send_beat(make_beat(FUNC_INSERT, 2, 32'sh1234_5678));
        // Read the whole list back, then one past its end.
        for (int k = 0; k <= 5; k++)
            send_beat(make_beat(FUNC_GET, k, 0));
        send_beat(make_beat(FUNC_SET, 4, 32'shA5A5_A5A5));
        send_beat(make_beat(FUNC_GET, 127, 0));
        send_beat(make_beat(FUNC_ERASE, 1, 0));
        send_beat(make_beat(FUNC_ERASE, 4, 0));
        send_beat(make_beat(FUNC_INSERT, 64, 32'sh5A5A_5A5A));
        send_beat(make_beat(FUNC_POP_BACK, 0, 0));
        send_beat(make_beat(FUNC_DROP_FRONT, 0, 0));
        send_beat(make_beat(FUNC_GET, 1, 0));

        run_random(RANDOM_BEATS);
        req_valid <= 1'b0;

        // Drain the outstanding responses, then give the pipeline a few more cycles so
        // that any spurious extra beat would still be caught.
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_indexed_insert_erase_list: clean");
        else
            $display("tb_indexed_insert_erase_list: errors");
        $finish;
    end

    // Watchdog: a correct run needs far less than this, even with every stall.
    initial
    begin
        #2_000_000;
        $display("tb_indexed_insert_erase_list: errors");
        $finish;
    end

endmodule
